// ===== hdl/tiw_pkg.sv =====
// Shared types and constants of the tensor index walker.
package tiw_pkg;

   localparam int NDIMS          = 4;
   localparam int FIELD_POS_BITS = 12;
   localparam int EXT_BITS       = 13;
   localparam int RANK_BITS      = 3;
   localparam int LAYOUT_BITS    = 8;
   localparam int DIM_SEL_BITS   = 2;
   localparam int LIN_BITS       = 48;
   // Extents stay below 2^EXT_BITS, and a stride feeds at most three extents.
   localparam int SCALE_BITS     = 3 * EXT_BITS;
   localparam int ADDR_BITS      = 5;
   localparam int DATA_BITS      = 32;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_RANK   = 3'd0,
      REG_DIM_0  = 3'd1,
      REG_DIM_1  = 3'd2,
      REG_DIM_2  = 3'd3,
      REG_DIM_3  = 3'd4,
      REG_LAYOUT = 3'd5
   } reg_type;

   typedef struct packed {
      logic [RANK_BITS-1:0]                 rank;
      logic [NDIMS-1:0][EXT_BITS-1:0]       dim_size;
      logic [LAYOUT_BITS-1:0]               layout;
   } cfg_type;

   typedef struct packed {
      op_type                               op;
      logic [RANK_BITS-1:0]                 rank;
      logic [NDIMS-1:0][FIELD_POS_BITS-1:0] pos;
   } cmd_type;

endpackage

// ===== hdl/tensor_index_walker_unit.sv =====
// Top level of the tensor index walker: register file, front end and back end.
//
// The tensor index walker holds a multidimensional index of up to four
// dimensions and turns it into a linear element offset. Each input word is
// either a load, which sets the index from the word's position fields, or an
// advance, which steps the index like an odometer with the last dimension in
// use moving fastest; when no dimension can move, the index stays put and the
// exhausted flag is set. Every input word yields exactly one result word with
// the current positions and the offset, which is summed over the layout order
// held in the layout register with strides that are running products of the
// extents. Input words enter a two-deep command queue, so the block keeps
// taking words while the execution unit works and while a result waits on the
// output. For each word the execution unit takes the command, updates the
// index, runs the shared multiply-accumulate over the dimensions in use to
// build the offset and hands the result to the output register; that single
// multiply-accumulate sets the throughput while the output is not held.
// The registers are written through the APB-style port at byte address
// 4 * index and should only be changed while no words are in flight.
module tensor_index_walker_unit
   import tiw_pkg::*;
#(
   parameter int MAX_RANK = 4,
   parameter int POS_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_func,
   input  logic [FIELD_POS_BITS-1:0]  req_load_pos_0,
   input  logic [FIELD_POS_BITS-1:0]  req_load_pos_1,
   input  logic [FIELD_POS_BITS-1:0]  req_load_pos_2,
   input  logic [FIELD_POS_BITS-1:0]  req_load_pos_3,
   output logic                       empty,
   input  logic                       pop,
   output logic [LIN_BITS-1:0]        rsp_elem_offset,
   output logic                       rsp_exhausted,
   output logic [FIELD_POS_BITS-1:0]  rsp_pos_0,
   output logic [FIELD_POS_BITS-1:0]  rsp_pos_1,
   output logic [FIELD_POS_BITS-1:0]  rsp_pos_2,
   output logic [FIELD_POS_BITS-1:0]  rsp_pos_3,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_BITS-1:0]       paddr,
   input  logic [DATA_BITS-1:0]       pwdata,
   output logic [DATA_BITS-1:0]       prdata,
   output logic                       pready
);

   cfg_type                               cfg_ff, cfg_in;
   reg_type                               reg_sel;
   logic                                  csr_write;
   logic [NDIMS-1:0][FIELD_POS_BITS-1:0]  load_pos;
   logic [NDIMS-1:0][FIELD_POS_BITS-1:0]  rsp_pos;
   logic                                  cmd_valid;
   logic                                  cmd_take;
   cmd_type                               cmd;

   // The register port never inserts wait states.
   assign pready    = 1'b1;
   assign reg_sel   = reg_type'(paddr[ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes; addresses past the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_RANK:   cfg_in.rank        = pwdata[RANK_BITS-1:0];
            REG_DIM_0:  cfg_in.dim_size[0] = pwdata[EXT_BITS-1:0];
            REG_DIM_1:  cfg_in.dim_size[1] = pwdata[EXT_BITS-1:0];
            REG_DIM_2:  cfg_in.dim_size[2] = pwdata[EXT_BITS-1:0];
            REG_DIM_3:  cfg_in.dim_size[3] = pwdata[EXT_BITS-1:0];
            REG_LAYOUT: cfg_in.layout      = pwdata[LAYOUT_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RANK:   prdata = DATA_BITS'(cfg_ff.rank);
         REG_DIM_0:  prdata = DATA_BITS'(cfg_ff.dim_size[0]);
         REG_DIM_1:  prdata = DATA_BITS'(cfg_ff.dim_size[1]);
         REG_DIM_2:  prdata = DATA_BITS'(cfg_ff.dim_size[2]);
         REG_DIM_3:  prdata = DATA_BITS'(cfg_ff.dim_size[3]);
         REG_LAYOUT: prdata = DATA_BITS'(cfg_ff.layout);
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Reset gives rank four, unit extents and a row-major layout.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank     <= RANK_BITS'(4);
         cfg_ff.dim_size <= {NDIMS{EXT_BITS'(1)}};
         cfg_ff.layout   <= LAYOUT_BITS'(27);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign load_pos[0] = req_load_pos_0;
   assign load_pos[1] = req_load_pos_1;
   assign load_pos[2] = req_load_pos_2;
   assign load_pos[3] = req_load_pos_3;

   tiw_front #(
      .MAX_RANK (MAX_RANK),
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .func      (req_func),
      .load_pos  (load_pos),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   tiw_back #(
      .MAX_RANK (MAX_RANK),
      .POS_BITS (POS_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_take        (cmd_take),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .pop             (pop),
      .empty           (empty),
      .rsp_elem_offset (rsp_elem_offset),
      .rsp_exhausted   (rsp_exhausted),
      .rsp_pos         (rsp_pos)
   );

   assign rsp_pos_0 = rsp_pos[0];
   assign rsp_pos_1 = rsp_pos[1];
   assign rsp_pos_2 = rsp_pos[2];
   assign rsp_pos_3 = rsp_pos[3];

   // The execution unit only takes a command that the queue really holds.
   a_take_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from an empty queue");

   // A full queue always offers a command to the execution unit.
   a_full_has_cmd: assert property (@(posedge clock) disable iff (reset)
      full |-> cmd_valid)
      else $error("queue reports full without a command");

   // An accepted word is visible to the execution unit on the next cycle.
   a_push_reaches_back: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> cmd_valid)
      else $error("accepted word lost before the execution unit");

endmodule

// ===== hdl/tiw_front.sv =====
// Front end: takes input words, decodes them into commands and queues them.
module tiw_front
   import tiw_pkg::*;
#(
   parameter int MAX_RANK = 4,
   parameter int POS_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  func,
   input  logic [NDIMS-1:0][FIELD_POS_BITS-1:0]  load_pos,
   input  cfg_type                               cfg,
   output logic                                  cmd_valid,
   input  logic                                  cmd_take,
   output cmd_type                               cmd
);

   localparam int NumDims  = (MAX_RANK < NDIMS) ? MAX_RANK : NDIMS;
   localparam int MaskBits = (POS_BITS < FIELD_POS_BITS) ? POS_BITS : FIELD_POS_BITS;
   localparam logic [FIELD_POS_BITS-1:0] LoadMask =
      FIELD_POS_BITS'((33'd1 << MaskBits) - 33'd1);

   logic [RANK_BITS-1:0] eff_rank;
   cmd_type              cmd_in;
   cmd_type              q_ff [QUEUE_DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push_ok;

   // Rank zero behaves as one; ranks beyond the built dimensions are clamped.
   always_comb begin
      if (cfg.rank == '0) begin
         eff_rank = RANK_BITS'(1);
      end else if (cfg.rank > RANK_BITS'(NumDims)) begin
         eff_rank = RANK_BITS'(NumDims);
      end else begin
         eff_rank = cfg.rank;
      end
   end

   always_comb begin
      cmd_in.op   = op_type'(func);
      cmd_in.rank = eff_rank;
      for (int i = 0; i < NDIMS; i++) begin
         cmd_in.pos[i] = (RANK_BITS'(i) < eff_rank) ? (load_pos[i] & LoadMask) : '0;
      end
   end

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign push_ok   = push && !full;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== hdl/tiw_back.sv =====
// Back end: updates the index, accumulates the linear offset, holds the result.
module tiw_back
   import tiw_pkg::*;
#(
   parameter int MAX_RANK = 4,
   parameter int POS_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   output logic                                  cmd_take,
   input  cmd_type                               cmd,
   input  cfg_type                               cfg,
   input  logic                                  pop,
   output logic                                  empty,
   output logic [LIN_BITS-1:0]                   rsp_elem_offset,
   output logic                                  rsp_exhausted,
   output logic [NDIMS-1:0][FIELD_POS_BITS-1:0]  rsp_pos
);

   localparam int NumDims  = (MAX_RANK < NDIMS) ? MAX_RANK : NDIMS;
   localparam int CmpBits  = (POS_BITS + 1 > EXT_BITS) ? POS_BITS + 1 : EXT_BITS;
   localparam int TermBits = SCALE_BITS + POS_BITS;
   localparam int ProdBits = SCALE_BITS + CmpBits;
   localparam logic [CmpBits-1:0] ExtCap = CmpBits'(1) << POS_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_STEP = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [POS_BITS-1:0]      pos_ff [NumDims];
   logic [POS_BITS-1:0]      pos_in [NumDims];
   logic                     exh_ff, exh_in;
   logic [LIN_BITS-1:0]      sum_ff, sum_in;
   logic [SCALE_BITS-1:0]    scale_ff, scale_in;
   logic [RANK_BITS-1:0]     k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;
   logic [CmpBits-1:0]       ext [NDIMS];
   logic [NumDims-1:0]       can_inc;
   logic                     hit;
   logic [RANK_BITS-1:0]     sel;
   logic [DIM_SEL_BITS-1:0]  d;
   logic                     d_used;
   logic [POS_BITS-1:0]      pos_sel;
   logic [TermBits-1:0]      term;
   logic [ProdBits-1:0]      scale_prod;
   logic [FIELD_POS_BITS-1:0] pos_out [NDIMS];

   // Extents above the position range act as that range.
   always_comb begin
      for (int i = 0; i < NDIMS; i++) begin
         ext[i] = (CmpBits'(cfg.dim_size[i]) > ExtCap) ? ExtCap : CmpBits'(cfg.dim_size[i]);
      end
   end

   // Odometer step: the highest dimension in use that can still move wins.
   always_comb begin
      hit = 1'b0;
      sel = '0;
      for (int i = 0; i < NumDims; i++) begin
         can_inc[i] = (CmpBits'(pos_ff[i]) + CmpBits'(1)) < ext[i];
         if ((RANK_BITS'(i) < cmd_ff.rank) && can_inc[i]) begin
            hit = 1'b1;
            sel = RANK_BITS'(i);
         end
      end
   end

   // Offset term for layout entry k.
   always_comb begin
      d       = cfg.layout[{k_ff[DIM_SEL_BITS-1:0], 1'b0} +: DIM_SEL_BITS];
      d_used  = (RANK_BITS'(d) < cmd_ff.rank);
      pos_sel = '0;
      for (int i = 0; i < NumDims; i++) begin
         if (d == DIM_SEL_BITS'(i)) begin
            pos_sel = pos_ff[i];
         end
      end
      term       = TermBits'(scale_ff) * TermBits'(pos_sel);
      scale_prod = ProdBits'(scale_ff) * ProdBits'(ext[d]);
   end

   // Dimensions that are not built read back as zero.
   always_comb begin
      for (int i = 0; i < NDIMS; i++) begin
         pos_out[i] = '0;
      end
      for (int i = 0; i < NumDims; i++) begin
         pos_out[i] = FIELD_POS_BITS'(pos_ff[i]);
      end
   end

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || pop);
   assign empty    = !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      exh_in       = exh_ff;
      sum_in       = sum_ff;
      scale_in     = scale_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      for (int i = 0; i < NumDims; i++) begin
         pos_in[i] = pos_ff[i];
      end
      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (cmd_ff.op == OP_LOAD) begin
               exh_in = 1'b0;
               for (int i = 0; i < NumDims; i++) begin
                  pos_in[i] = POS_BITS'(cmd_ff.pos[i]);
               end
            end else begin
               exh_in = !hit;
               for (int i = 0; i < NumDims; i++) begin
                  if (RANK_BITS'(i) >= cmd_ff.rank) begin
                     pos_in[i] = '0;
                  end else if (hit && (RANK_BITS'(i) == sel)) begin
                     pos_in[i] = pos_ff[i] + POS_BITS'(1);
                  end else if (hit && (RANK_BITS'(i) > sel)) begin
                     pos_in[i] = '0;
                  end
               end
            end
            sum_in   = '0;
            scale_in = SCALE_BITS'(1);
            k_in     = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (d_used) begin
               sum_in   = sum_ff + LIN_BITS'(term);
               scale_in = SCALE_BITS'(scale_prod);
            end
            k_in = k_ff + RANK_BITS'(1);
            if (k_in == cmd_ff.rank) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumDims; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NumDims; i++) begin
            pos_ff[i] <= pos_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      exh_ff   <= exh_in;
      sum_ff   <= sum_in;
      scale_ff <= scale_in;
      k_ff     <= k_in;
      if (cmd_take) begin
         cmd_ff <= cmd;
      end
      if (rsp_load) begin
         rsp_elem_offset <= sum_ff;
         rsp_exhausted   <= exh_ff;
         for (int i = 0; i < NDIMS; i++) begin
            rsp_pos[i] <= pos_out[i];
         end
      end
   end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the tensor index walker: directed and random index walks.
module tb;
   import tiw_pkg::*;

   // The instance runs with its default parameters; the predictor mirrors them.
   localparam int MAX_RANK       = 4;
   localparam int POS_BITS       = 12;
   localparam int POS_LIMIT      = 1 << POS_BITS;
   // Cycles with no handshake on either side before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;
   // Extra cycles run after every predicted result has come back, before the verdict.
   localparam int TAIL_CYCLES    = 16;

   typedef struct packed {
      logic [LIN_BITS-1:0]                  elem_offset;
      logic                                 exhausted;
      logic [NDIMS-1:0][FIELD_POS_BITS-1:0] pos;
   } walk_result_type;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic                      req_func;
   logic [FIELD_POS_BITS-1:0] req_load_pos_0;
   logic [FIELD_POS_BITS-1:0] req_load_pos_1;
   logic [FIELD_POS_BITS-1:0] req_load_pos_2;
   logic [FIELD_POS_BITS-1:0] req_load_pos_3;
   logic                      empty;
   logic                      pop;
   logic [LIN_BITS-1:0]       rsp_elem_offset;
   logic                      rsp_exhausted;
   logic [FIELD_POS_BITS-1:0] rsp_pos_0;
   logic [FIELD_POS_BITS-1:0] rsp_pos_1;
   logic [FIELD_POS_BITS-1:0] rsp_pos_2;
   logic [FIELD_POS_BITS-1:0] rsp_pos_3;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [ADDR_BITS-1:0]      paddr;
   logic [DATA_BITS-1:0]      pwdata;
   logic [DATA_BITS-1:0]      prdata;
   logic                      pready;

   // Shadow copy of the register file and of the current index.
   logic [RANK_BITS-1:0]      walker_rank;
   logic [EXT_BITS-1:0]       walker_extent [NDIMS];
   logic [LAYOUT_BITS-1:0]    walker_layout;
   logic [FIELD_POS_BITS-1:0] walker_pos [NDIMS];

   // Results predicted for accepted words, oldest first.
   walk_result_type pending_walks[$];

   int mismatches;
   int quiet_cycles;
   int send_idle_pct;
   int recv_idle_pct;

   tensor_index_walker_unit uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_func         (req_func),
      .req_load_pos_0   (req_load_pos_0),
      .req_load_pos_1   (req_load_pos_1),
      .req_load_pos_2   (req_load_pos_2),
      .req_load_pos_3   (req_load_pos_3),
      .empty            (empty),
      .pop              (pop),
      .rsp_elem_offset  (rsp_elem_offset),
      .rsp_exhausted    (rsp_exhausted),
      .rsp_pos_0        (rsp_pos_0),
      .rsp_pos_1        (rsp_pos_1),
      .rsp_pos_2        (rsp_pos_2),
      .rsp_pos_3        (rsp_pos_3),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // An extent above the position range steps and scales like the full range.
   function automatic int clipped_extent(logic [EXT_BITS-1:0] extent);
      return (extent > POS_LIMIT) ? POS_LIMIT : int'(extent);
   endfunction

   // Applies one word to the shadow index and returns the result it must yield.
   function automatic walk_result_type predict_index_step(op_type op,
         logic [FIELD_POS_BITS-1:0] p0, logic [FIELD_POS_BITS-1:0] p1,
         logic [FIELD_POS_BITS-1:0] p2, logic [FIELD_POS_BITS-1:0] p3);
      walk_result_type           res;
      logic [FIELD_POS_BITS-1:0] load [NDIMS];
      logic [LIN_BITS-1:0]       sum;
      logic [LIN_BITS-1:0]       scale;
      int                        r;
      int                        d;
      int                        i;
      int                        j;
      int                        k;
      bit                        moved;
      load[0] = p0;
      load[1] = p1;
      load[2] = p2;
      load[3] = p3;
      // A rank of zero behaves as one, anything above the limit as the limit.
      r = walker_rank;
      if (r == 0) r = 1;
      if (r > MAX_RANK) r = MAX_RANK;
      if (r > NDIMS) r = NDIMS;
      res.exhausted = 1'b0;
      if (op == OP_LOAD) begin
         for (i = 0; i < NDIMS; i++) walker_pos[i] = (i < r) ? load[i] : '0;
      end else begin
         // Dimensions outside the rank are cleared before stepping.
         for (i = r; i < NDIMS; i++) walker_pos[i] = '0;
         moved = 1'b0;
         for (i = r - 1; i >= 0 && !moved; i--) begin
            if (int'(walker_pos[i]) + 1 < clipped_extent(walker_extent[i])) begin
               walker_pos[i] = walker_pos[i] + 1'b1;
               for (j = i + 1; j < NDIMS; j++) walker_pos[j] = '0;
               moved = 1'b1;
            end
         end
         // With no dimension able to move, the index stays where it was.
         res.exhausted = !moved;
      end
      // Offset over the minor-to-major order; entries outside the rank are skipped.
      sum   = '0;
      scale = 1;
      for (k = 0; k < r; k++) begin
         d = walker_layout[2*k +: 2];
         if (d < r) begin
            sum   = sum + scale * walker_pos[d];
            scale = scale * LIN_BITS'(clipped_extent(walker_extent[d]));
         end
      end
      res.elem_offset = sum;
      for (i = 0; i < NDIMS; i++) res.pos[i] = walker_pos[i];
      return res;
   endfunction

   // Offers one word until the block takes it; push is left high on return.
   task automatic send_word(op_type op, logic [FIELD_POS_BITS-1:0] p0,
         logic [FIELD_POS_BITS-1:0] p1, logic [FIELD_POS_BITS-1:0] p2,
         logic [FIELD_POS_BITS-1:0] p3);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push           <= 1'b1;
      req_func       <= op;
      req_load_pos_0 <= p0;
      req_load_pos_1 <= p1;
      req_load_pos_2 <= p2;
      req_load_pos_3 <= p3;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      pending_walks.push_back(predict_index_step(op, p0, p1, p2, p3));
   endtask

   // Stops sending and waits until every predicted word has come back.
   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(reg_type sel, logic [DATA_BITS-1:0] value);
      drain_results();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      case (sel)
         REG_RANK:   walker_rank      = value[RANK_BITS-1:0];
         REG_DIM_0:  walker_extent[0] = value[EXT_BITS-1:0];
         REG_DIM_1:  walker_extent[1] = value[EXT_BITS-1:0];
         REG_DIM_2:  walker_extent[2] = value[EXT_BITS-1:0];
         REG_DIM_3:  walker_extent[3] = value[EXT_BITS-1:0];
         REG_LAYOUT: walker_layout    = value[LAYOUT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_shape(int rank, int e0, int e1, int e2, int e3, int layout);
      write_register(REG_RANK, rank);
      write_register(REG_DIM_0, e0);
      write_register(REG_DIM_1, e1);
      write_register(REG_DIM_2, e2);
      write_register(REG_DIM_3, e3);
      write_register(REG_LAYOUT, layout);
   endtask

   // Out of reset every extent is one, so nothing can step.
   task automatic test_reset_state();
      send_word(OP_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      send_word(OP_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000);
   endtask

   task automatic test_load_extremes();
      program_shape(4, 4096, 4096, 4096, 4096, 32'h1B);
      send_word(OP_LOAD, 12'h000, 12'h000, 12'h000, 12'h000);
      send_word(OP_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      send_word(OP_LOAD, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
   endtask

   // Column-major layout; the fourth dimension is outside the rank.
   task automatic test_odometer_carry();
      program_shape(3, 2, 3, 2, 9, 32'hE4);
      send_word(OP_LOAD, 12'd1, 12'd2, 12'd0, 12'd7);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      send_word(OP_LOAD, 12'd0, 12'd2, 12'd1, 12'd0);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
   endtask

   // Rank zero acts as one, rank seven as the maximum, and a lowered rank
   // clears the upper positions on the next advance.
   task automatic test_rank_limits();
      program_shape(0, 5, 5, 5, 5, 32'hE4);
      send_word(OP_LOAD, 12'd3, 12'd1, 12'd1, 12'd1);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      write_register(REG_RANK, 32'd7);
      send_word(OP_LOAD, 12'd1, 12'd2, 12'd3, 12'd4);
      write_register(REG_RANK, 32'd2);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
   endtask

   // A zero extent never steps and zeroes later strides; an oversized extent
   // behaves as the full position range.
   task automatic test_extent_edges();
      program_shape(2, 0, 8191, 1, 1, 32'h01);
      send_word(OP_LOAD, 12'd5, 12'd4094, 12'd0, 12'd0);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      send_word(OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0);
      write_register(REG_LAYOUT, 32'h04);
      send_word(OP_LOAD, 12'd7, 12'd100, 12'd0, 12'd0);
   endtask

   // Repeated layout entries at full size reach the top of the offset range,
   // and a rank-three layout naming dimension three skips that entry.
   task automatic test_layout_entries();
      program_shape(4, 8191, 4097, 4096, 4096, 32'h00);
      send_word(OP_LOAD, 12'hFFF, 12'h123, 12'h456, 12'h789);
      write_register(REG_LAYOUT, 32'h1B);
      send_word(OP_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      program_shape(3, 3, 4, 5, 6, 32'h13);
      send_word(OP_LOAD, 12'd2, 12'd3, 12'd4, 12'd5);
   endtask

   function automatic logic [EXT_BITS-1:0] pick_extent();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return EXT_BITS'($urandom_range(1, 5));
      if (sel < 75) return '0;
      if (sel < 85) return EXT_BITS'($urandom_range(4090, 4100));
      return EXT_BITS'($urandom_range(0, 8191));
   endfunction

   // Half of the positions sit at or just below the end of the extent, so that
   // advances carry and run out; a fifth lie inside the extent, the rest are arbitrary.
   function automatic logic [FIELD_POS_BITS-1:0] pick_position(int dim);
      int extent;
      int sel;
      extent = clipped_extent(walker_extent[dim]);
      sel    = $urandom_range(99);
      if (extent == 0 || sel >= 70) begin
         return FIELD_POS_BITS'($urandom_range(0, POS_LIMIT - 1));
      end
      if (sel < 50) begin
         return FIELD_POS_BITS'(extent - 1 -
                                $urandom_range(0, (extent > 3) ? 2 : extent - 1));
      end
      return FIELD_POS_BITS'($urandom_range(0, extent - 1));
   endfunction

   task automatic send_random_load();
      send_word(OP_LOAD, pick_position(0), pick_position(1), pick_position(2),
                pick_position(3));
   endtask

   task automatic randomize_shape();
      int perm [NDIMS];
      int i;
      int j;
      int t;
      int rank;
      int layout;
      rank = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      if ($urandom_range(99) < 60) begin
         for (i = 0; i < NDIMS; i++) perm[i] = i;
         for (i = NDIMS - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
         layout = 0;
         for (i = 0; i < NDIMS; i++) layout = layout | (perm[i] << (2 * i));
      end else begin
         layout = $urandom_range(0, 255);
      end
      program_shape(rank, pick_extent(), pick_extent(), pick_extent(), pick_extent(),
                    layout);
   endtask

   // Walks: a fresh shape, a load, then a run of advances with a few stray
   // loads mixed in.
   task automatic test_random_walks(int sender_pct, int receiver_pct, int budget);
      int sent;
      int steps;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sent = 0;
      while (sent < budget) begin
         randomize_shape();
         send_random_load();
         sent++;
         steps = $urandom_range(4, 40);
         repeat (steps) begin
            if ($urandom_range(9) == 0) begin
               send_random_load();
            end else begin
               send_word(OP_ADVANCE,
                         FIELD_POS_BITS'($urandom_range(0, POS_LIMIT - 1)),
                         FIELD_POS_BITS'($urandom_range(0, POS_LIMIT - 1)),
                         FIELD_POS_BITS'($urandom_range(0, POS_LIMIT - 1)),
                         FIELD_POS_BITS'($urandom_range(0, POS_LIMIT - 1)));
            end
            sent++;
         end
      end
   endtask

   task automatic report_field(string name, logic [LIN_BITS-1:0] want,
         logic [LIN_BITS-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // The receiver stalls at random; pop changes only at falling edges.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every word taken from the output is checked against the oldest prediction.
   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && pop && empty === 1'b0) begin
         if (pending_walks.size() == 0) begin
            mismatches++;
            $display("%0t: result word with nothing expected, offset %0d", $time,
                     rsp_elem_offset);
         end else begin
            want = pending_walks.pop_front();
            report_field("elem_offset", want.elem_offset, rsp_elem_offset);
            report_field("exhausted", want.exhausted, rsp_exhausted);
            report_field("pos_0", want.pos[0], rsp_pos_0);
            report_field("pos_1", want.pos[1], rsp_pos_1);
            report_field("pos_2", want.pos[2], rsp_pos_2);
            report_field("pos_3", want.pos[3], rsp_pos_3);
         end
      end
   end

   // A stretch without any handshake means the block has hung.
   always @(posedge clock) begin
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tensor_index_walker_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int i;
      reset          = 1'b1;
      push           = 1'b0;
      pop            = 1'b0;
      req_func       = 1'b0;
      req_load_pos_0 = '0;
      req_load_pos_1 = '0;
      req_load_pos_2 = '0;
      req_load_pos_3 = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      mismatches     = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 26;
      recv_idle_pct  = 63;
      // Shadow state matches the block's reset: row-major, unit extents.
      walker_rank   = 3'd4;
      walker_layout = 8'h1B;
      for (i = 0; i < NDIMS; i++) begin
         walker_extent[i] = 1;
         walker_pos[i]    = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_extremes();
      test_odometer_carry();
      test_rank_limits();
      test_extent_edges();
      test_layout_entries();
      test_random_walks(26, 63, 515);
      test_random_walks(63, 26, 515);
      test_random_walks(0, 0, 520);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_walks.size() == 0) begin
         $display("tensor_index_walker_unit: match");
      end else begin
         $display("tensor_index_walker_unit: mismatch");
      end
      $finish;
   end

endmodule
